### sv/srp_pkg.sv
// Package for the SOCKS5 request parser: beat types, phase encoding and protocol constants.
package srp_pkg;

  // Parser phases, one per field of the request, plus a done phase.
  typedef enum logic [2:0] {
    PH_VERSION = 3'd0,
    PH_CMD     = 3'd1,
    PH_RSV     = 3'd2,
    PH_ATYP    = 3'd3,
    PH_DNLEN   = 3'd4,
    PH_ADDR    = 3'd5,
    PH_PORT    = 3'd6,
    PH_DONE    = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    ST_BUSY  = 2'd0,
    ST_OK    = 2'd1,
    ST_ERROR = 2'd2
  } status_e;

  localparam logic [7:0] SocksVersion = 8'd5;
  localparam logic [7:0] CmdConnect   = 8'd1;
  localparam logic [7:0] RsvValue     = 8'h00;
  localparam logic [7:0] AtypV4       = 8'd1;
  localparam logic [7:0] AtypDomain   = 8'd3;
  localparam logic [7:0] AtypV6       = 8'd4;
  localparam logic [7:0] LenV4        = 8'd4;
  localparam logic [7:0] LenV6        = 8'd16;
  localparam logic [7:0] PortLen      = 8'd2;

  localparam logic [3:0] CodeOk      = 4'd0;
  localparam logic [3:0] CodeGeneral = 4'd1;
  localparam logic [3:0] CodeCommand = 4'd7;
  localparam logic [3:0] CodeAtyp    = 4'd8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } srp_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  reply_code;
    logic [7:0]  addr_type;
    logic        addr_valid;
    logic [7:0]  addr_index;
    logic [7:0]  addr_byte;
    logic [15:0] dest_port;
  } srp_out_t;

endpackage

### sv/socks5_request_parser.sv
// Top level of the SOCKS5 request parser: input register, parser and result register.
// A byte accepted into the input register is parsed when the result register is free, and its
// result beat is held in the result register until it is taken.
// Throughput: one byte per cycle while the result beat is not stalled; the block holds at most two beats, and the
// input stalls only while both registers are full and the result beat is stalled.
// Reset: rst_ni is asynchronous and active low; it empties both registers and
// returns the parser to the version phase with all counters cleared.
module socks5_request_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  srp_pkg::srp_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output srp_pkg::srp_out_t out_data_o
);

  // Input register: holds one request byte waiting for the parser.
  logic              in_valid_q;
  srp_pkg::srp_in_t  in_q;
  // Result register: holds one finished result beat for the consumer.
  logic              out_valid_q;
  srp_pkg::srp_out_t out_q;

  srp_pkg::srp_out_t res;
  srp_pkg::phase_e   phase;
  logic              step;
  logic              in_free;

  // The parser consumes the held byte whenever the result register is empty
  // or its beat is being taken in this cycle.
  assign step    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_free = !in_valid_q || step;

  assign in_stall_o  = !in_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_free) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_free && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  // The parser state advances exactly once per byte that reaches the result register.
  srp_fsm u_fsm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (in_q),
    .res_o   (res),
    .phase_o (phase)
  );

`ifndef SYNTH
  // A byte taken by the parser always lands in the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) step |=> out_valid_q)
    else $error("parsed beat was not registered");

  // An error result always carries a nonzero reply code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == srp_pkg::ST_ERROR) |-> (out_q.reply_code != srp_pkg::CodeOk))
    else $error("error beat without a reply code");

  // An address byte is never the last byte of a request, so status is still busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.addr_valid) |-> (out_q.status == srp_pkg::ST_BUSY))
    else $error("address byte with a final status");

  // Once finished, the parser stays finished until a restart arrives.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && !in_q.restart && phase == srp_pkg::PH_DONE) |=> (phase == srp_pkg::PH_DONE))
    else $error("parser left the done phase without a restart");
`endif

endmodule

### sv/srp_fsm.sv
// Parser state registers and the per-byte next-state and result logic.
module srp_fsm (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  srp_pkg::srp_in_t item_i,
  output srp_pkg::srp_out_t res_o,
  output srp_pkg::phase_e  phase_o
);

  srp_pkg::phase_e phase_q, phase_d, phase_s;
  logic [3:0]  final_code_q, final_code_d, final_code_s;
  logic [7:0]  byte_count_q, byte_count_d, byte_count_s;
  logic [7:0]  addr_total_q, addr_total_d, addr_total_s;
  logic [15:0] port_acc_q, port_acc_d, port_acc_s;
  logic [7:0]  atyp_seen_q, atyp_seen_d, atyp_seen_s;
  logic [7:0]  count_inc;
  logic [7:0]  c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= srp_pkg::PH_VERSION;
      final_code_q <= srp_pkg::CodeOk;
      byte_count_q <= '0;
      addr_total_q <= '0;
      port_acc_q   <= '0;
      atyp_seen_q  <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      final_code_q <= final_code_d;
      byte_count_q <= byte_count_d;
      addr_total_q <= addr_total_d;
      port_acc_q   <= port_acc_d;
      atyp_seen_q  <= atyp_seen_d;
    end
  end

  always_comb begin
    c = item_i.data_byte;
    // A restart clears the state before the byte is looked at.
    if (item_i.restart) begin
      phase_s      = srp_pkg::PH_VERSION;
      final_code_s = srp_pkg::CodeOk;
      byte_count_s = '0;
      addr_total_s = '0;
      port_acc_s   = '0;
      atyp_seen_s  = '0;
    end else begin
      phase_s      = phase_q;
      final_code_s = final_code_q;
      byte_count_s = byte_count_q;
      addr_total_s = addr_total_q;
      port_acc_s   = port_acc_q;
      atyp_seen_s  = atyp_seen_q;
    end

    phase_d      = phase_s;
    final_code_d = final_code_s;
    byte_count_d = byte_count_s;
    addr_total_d = addr_total_s;
    port_acc_d   = port_acc_s;
    atyp_seen_d  = atyp_seen_s;
    count_inc    = byte_count_s + 8'd1;

    res_o            = '0;
    res_o.addr_valid = 1'b0;

    unique case (phase_s)
      srp_pkg::PH_VERSION: begin
        if (c == srp_pkg::SocksVersion) begin
          phase_d = srp_pkg::PH_CMD;
        end else begin
          phase_d      = srp_pkg::PH_DONE;
          final_code_d = srp_pkg::CodeGeneral;
        end
      end
      srp_pkg::PH_CMD: begin
        if (c == srp_pkg::CmdConnect) begin
          phase_d = srp_pkg::PH_RSV;
        end else begin
          phase_d      = srp_pkg::PH_DONE;
          final_code_d = srp_pkg::CodeCommand;
        end
      end
      srp_pkg::PH_RSV: begin
        if (c == srp_pkg::RsvValue) begin
          phase_d = srp_pkg::PH_ATYP;
        end else begin
          phase_d      = srp_pkg::PH_DONE;
          final_code_d = srp_pkg::CodeGeneral;
        end
      end
      srp_pkg::PH_ATYP: begin
        atyp_seen_d  = c;
        byte_count_d = '0;
        if (c == srp_pkg::AtypV4) begin
          addr_total_d = srp_pkg::LenV4;
          phase_d      = srp_pkg::PH_ADDR;
        end else if (c == srp_pkg::AtypV6) begin
          addr_total_d = srp_pkg::LenV6;
          phase_d      = srp_pkg::PH_ADDR;
        end else if (c == srp_pkg::AtypDomain) begin
          phase_d = srp_pkg::PH_DNLEN;
        end else begin
          phase_d      = srp_pkg::PH_DONE;
          final_code_d = srp_pkg::CodeAtyp;
        end
      end
      srp_pkg::PH_DNLEN: begin
        addr_total_d = c;
        byte_count_d = '0;
        // An empty domain name cannot be connected to.
        if (c == 8'd0) begin
          phase_d      = srp_pkg::PH_DONE;
          final_code_d = srp_pkg::CodeGeneral;
        end else begin
          phase_d = srp_pkg::PH_ADDR;
        end
      end
      srp_pkg::PH_ADDR: begin
        res_o.addr_valid = 1'b1;
        res_o.addr_index = byte_count_s;
        res_o.addr_byte  = c;
        if (count_inc == addr_total_s) begin
          byte_count_d = '0;
          phase_d      = srp_pkg::PH_PORT;
        end else begin
          byte_count_d = count_inc;
        end
      end
      srp_pkg::PH_PORT: begin
        port_acc_d = {port_acc_s[7:0], c};
        if (count_inc >= srp_pkg::PortLen) begin
          byte_count_d = '0;
          final_code_d = srp_pkg::CodeOk;
          phase_d      = srp_pkg::PH_DONE;
        end else begin
          byte_count_d = count_inc;
        end
      end
      srp_pkg::PH_DONE: begin
        // Finished: bytes are dropped until a restart.
      end
      default: begin
      end
    endcase

    if (phase_d == srp_pkg::PH_DONE) begin
      res_o.status     = (final_code_d == srp_pkg::CodeOk) ? srp_pkg::ST_OK : srp_pkg::ST_ERROR;
      res_o.reply_code = final_code_d;
    end else begin
      res_o.status     = srp_pkg::ST_BUSY;
      res_o.reply_code = srp_pkg::CodeOk;
    end
    res_o.addr_type = atyp_seen_d;
    res_o.dest_port = port_acc_d;
  end

  assign phase_o = phase_q;

endmodule
